// ----- rtl/core/brush_pixel_colour_core_assert.svh -----
// Assertion macros shared by the brush pixel colour RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BRUSH_PIXEL_COLOUR_CORE_ASSERT_SVH
`define BRUSH_PIXEL_COLOUR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bpc_pkg.sv -----
// Package for the brush pixel colour core: widths, pipeline depths, codes and
// the shared long-division step. Used by brush_pixel_colour_core.
package bpc_pkg;

	localparam int FRAC_W    = 10;
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int DIR_W     = 12;
	localparam int PROD_W    = DIR_W + DIFF_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int P_W       = SUM_W - FRAC_W;
	localparam int LEN_W     = 17;
	localparam int CH_W      = 8;
	localparam int STEP_N    = 2;
	localparam int MOD_STG   = (P_W + STEP_N - 1) / STEP_N;
	localparam int MOD_NUM_W = MOD_STG * STEP_N;
	localparam int NUM_W     = CH_W + LEN_W;
	localparam int DIV_STG   = (NUM_W + STEP_N - 1) / STEP_N;
	localparam int DIV_NUM_W = DIV_STG * STEP_N;
	localparam int LAT       = MOD_STG + DIV_STG + 7;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;

	localparam logic [1:0] MODE_HATCH = 2'd1;
	localparam logic [1:0] MODE_GRAD  = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_COL1   = 3'd1;
	localparam logic [2:0] REG_COL2   = 3'd2;
	localparam logic [2:0] REG_HATCH  = 3'd3;
	localparam logic [2:0] REG_START  = 3'd4;
	localparam logic [2:0] REG_COS    = 3'd5;
	localparam logic [2:0] REG_SIN    = 3'd6;
	localparam logic [2:0] REG_LEN    = 3'd7;

	typedef struct packed {
		logic valid;
		logic hbit;
	} side_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
			input logic nbit, input logic [LEN_W-1:0] len);
		logic [LEN_W:0] t;
		logic [LEN_W:0] d;
		t = {rem, nbit};
		d = t - {1'b0, len};
		if (t >= {1'b0, len})
			return {1'b1, d[LEN_W-1:0]};
		else
			return {1'b0, t[LEN_W-1:0]};
	endfunction

endpackage

// ----- rtl/core/brush_pixel_colour_core.sv -----
// Brush pixel colour core: maps a pixel coordinate to its ARGB brush colour.
// Depends on bpc_pkg and brush_pixel_colour_core_assert.svh.
//
// Usage: configure the brush through the APB port while the pipeline is
// empty; registers sit at byte address 8*i, 64-bit data, pready always high.
// Each cycle with start high and busy low takes one pixel beat (pixel_x,
// pixel_y). busy is never raised, so a beat may enter on every clock.
// The colour appears on pixel_argb with done high for exactly one cycle, once
// the beat has passed all bpc_pkg::LAT side-band registers; beats leave in
// entry order. Throughput is one pixel per clock. The latency is set by the
// two pipelined restoring dividers (floored modulo of the projection by the
// gradient length, then the per-channel interpolation divide), each retiring
// two quotient bits per stage, plus the multiply, sum and select stages.
// The receiver cannot stall: every done beat must be taken when it shows.
// Reset empties the pipeline and loads the register defaults (solid mode,
// colours zero, cos 1024, sin 0, length 1).
module brush_pixel_colour_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [bpc_pkg::COORD_W-1:0]  pixel_x,
	input  logic signed [bpc_pkg::COORD_W-1:0]  pixel_y,
	output logic                                done,
	output logic [31:0]                         pixel_argb,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bpc_pkg::ADDR_W-1:0]          paddr,
	input  logic [bpc_pkg::DATA_W-1:0]          pwdata,
	output logic [bpc_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	`include "brush_pixel_colour_core_assert.svh"

	logic [1:0]                        mode_q;
	logic [31:0]                       col1_q;
	logic [31:0]                       col2_q;
	logic [63:0]                       hatch_q;
	logic [31:0]                       start_q;
	logic signed [bpc_pkg::DIR_W-1:0]  cos_q;
	logic signed [bpc_pkg::DIR_W-1:0]  sin_q;
	logic [bpc_pkg::LEN_W-1:0]         len_q;
	logic [bpc_pkg::LEN_W-1:0]         len_eff;
	logic                              wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			col1_q  <= '0;
			col2_q  <= '0;
			hatch_q <= '0;
			start_q <= '0;
			cos_q   <= bpc_pkg::DIR_W'(1024);
			sin_q   <= '0;
			len_q   <= bpc_pkg::LEN_W'(1);
		end else if (wr_en) begin
			case (paddr[5:3])
				bpc_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
				bpc_pkg::REG_COL1:  col1_q  <= pwdata[31:0];
				bpc_pkg::REG_COL2:  col2_q  <= pwdata[31:0];
				bpc_pkg::REG_HATCH: hatch_q <= pwdata;
				bpc_pkg::REG_START: start_q <= pwdata[31:0];
				bpc_pkg::REG_COS:   cos_q   <= pwdata[bpc_pkg::DIR_W-1:0];
				bpc_pkg::REG_SIN:   sin_q   <= pwdata[bpc_pkg::DIR_W-1:0];
				bpc_pkg::REG_LEN:   len_q   <= pwdata[bpc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			bpc_pkg::REG_MODE:  prdata = 64'(mode_q);
			bpc_pkg::REG_COL1:  prdata = 64'(col1_q);
			bpc_pkg::REG_COL2:  prdata = 64'(col2_q);
			bpc_pkg::REG_HATCH: prdata = hatch_q;
			bpc_pkg::REG_START: prdata = 64'(start_q);
			bpc_pkg::REG_COS:   prdata = 64'(unsigned'(cos_q));
			bpc_pkg::REG_SIN:   prdata = 64'(unsigned'(sin_q));
			bpc_pkg::REG_LEN:   prdata = 64'(len_q);
			default:            prdata = '0;
		endcase
	end

	// A zero length behaves as a period of one pixel.
	assign len_eff = (len_q == '0) ? bpc_pkg::LEN_W'(1) : len_q;

	bpc_pkg::side_t side_sn [bpc_pkg::LAT];
	logic [5:0]     hidx;

	assign hidx = {pixel_y[2:0], pixel_x[2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bpc_pkg::LAT; i++)
				side_sn[i] <= '0;
		end else begin
			side_sn[0].valid <= start && !busy;
			side_sn[0].hbit  <= hatch_q[hidx];
			for (int i = 1; i < bpc_pkg::LAT; i++)
				side_sn[i] <= side_sn[i-1];
		end
	end

	logic signed [bpc_pkg::DIFF_W-1:0] dx_c;
	logic signed [bpc_pkg::DIFF_W-1:0] dy_c;
	logic signed [bpc_pkg::DIFF_W-1:0] dx_s1;
	logic signed [bpc_pkg::DIFF_W-1:0] dy_s1;
	logic signed [bpc_pkg::PROD_W-1:0] prodc_s2;
	logic signed [bpc_pkg::PROD_W-1:0] prods_s2;
	logic signed [bpc_pkg::SUM_W-1:0]  sum_c;
	logic [bpc_pkg::P_W-1:0]           p_s3;
	logic [bpc_pkg::P_W-1:0]           pabs_c;

	assign dx_c  = {pixel_x[bpc_pkg::COORD_W-1], pixel_x}
		- {start_q[15], start_q[15:0]};
	assign dy_c  = {pixel_y[bpc_pkg::COORD_W-1], pixel_y}
		- {start_q[31], start_q[31:16]};
	assign sum_c = {prodc_s2[bpc_pkg::PROD_W-1], prodc_s2}
		+ {prods_s2[bpc_pkg::PROD_W-1], prods_s2};
	assign pabs_c = p_s3[bpc_pkg::P_W-1] ? (~p_s3 + 1'b1) : p_s3;

	always_ff @(posedge clk) begin
		dx_s1    <= dx_c;
		dy_s1    <= dy_c;
		prodc_s2 <= cos_q * dx_s1;
		prods_s2 <= sin_q * dy_s1;
		p_s3     <= sum_c[bpc_pkg::SUM_W-1:bpc_pkg::FRAC_W];
	end

	logic [bpc_pkg::LEN_W-1:0]     mrem_sn [bpc_pkg::MOD_STG+1];
	logic [bpc_pkg::MOD_NUM_W-1:0] mnum_sn [bpc_pkg::MOD_STG+1];
	logic                          mneg_sn [bpc_pkg::MOD_STG+1];

	always_ff @(posedge clk) begin
		mrem_sn[0] <= '0;
		mnum_sn[0] <= bpc_pkg::MOD_NUM_W'(pabs_c);
		mneg_sn[0] <= p_s3[bpc_pkg::P_W-1];
	end

	for (genvar k = 1; k <= bpc_pkg::MOD_STG; k++) begin : g_mod
		logic [bpc_pkg::LEN_W-1:0]     rem_nx;
		logic [bpc_pkg::MOD_NUM_W-1:0] num_nx;

		always_comb begin
			logic [bpc_pkg::LEN_W:0] st;
			rem_nx = mrem_sn[k-1];
			num_nx = mnum_sn[k-1];
			for (int j = 0; j < bpc_pkg::STEP_N; j++) begin
				st     = bpc_pkg::div_step(rem_nx, num_nx[bpc_pkg::MOD_NUM_W-1], len_eff);
				rem_nx = st[bpc_pkg::LEN_W-1:0];
				num_nx = num_nx << 1;
			end
		end

		always_ff @(posedge clk) begin
			mrem_sn[k] <= rem_nx;
			mnum_sn[k] <= num_nx;
			mneg_sn[k] <= mneg_sn[k-1];
		end
	end

	logic [bpc_pkg::LEN_W-1:0] rfix_s;

	always_ff @(posedge clk) begin
		if (mneg_sn[bpc_pkg::MOD_STG] && mrem_sn[bpc_pkg::MOD_STG] != '0)
			rfix_s <= len_eff - mrem_sn[bpc_pkg::MOD_STG];
		else
			rfix_s <= mrem_sn[bpc_pkg::MOD_STG];
	end

	logic [bpc_pkg::CH_W-1:0]      cha   [4];
	logic [bpc_pkg::CH_W-1:0]      chb   [4];
	logic [bpc_pkg::CH_W-1:0]      dmag  [4];
	logic                          dneg  [4];
	logic [bpc_pkg::LEN_W-1:0]     drem_sn [bpc_pkg::DIV_STG+1][4];
	logic [bpc_pkg::DIV_NUM_W-1:0] dnum_sn [bpc_pkg::DIV_STG+1][4];
	logic [bpc_pkg::CH_W-1:0]      dq_sn   [bpc_pkg::DIV_STG+1][4];
	logic [31:0]                   grad_c;

	for (genvar c = 0; c < 4; c++) begin : g_ch
		assign cha[c]  = col1_q[8*c +: 8];
		assign chb[c]  = col2_q[8*c +: 8];
		assign dneg[c] = chb[c] < cha[c];
		assign dmag[c] = dneg[c] ? (cha[c] - chb[c]) : (chb[c] - cha[c]);

		always_ff @(posedge clk) begin
			drem_sn[0][c] <= '0;
			dq_sn[0][c]   <= '0;
			dnum_sn[0][c] <= bpc_pkg::DIV_NUM_W'(dmag[c] * rfix_s);
		end

		for (genvar k = 1; k <= bpc_pkg::DIV_STG; k++) begin : g_div
			logic [bpc_pkg::LEN_W-1:0]     rem_nx;
			logic [bpc_pkg::DIV_NUM_W-1:0] num_nx;
			logic [bpc_pkg::CH_W-1:0]      q_nx;

			always_comb begin
				logic [bpc_pkg::LEN_W:0] st;
				rem_nx = drem_sn[k-1][c];
				num_nx = dnum_sn[k-1][c];
				q_nx   = dq_sn[k-1][c];
				for (int j = 0; j < bpc_pkg::STEP_N; j++) begin
					st     = bpc_pkg::div_step(rem_nx, num_nx[bpc_pkg::DIV_NUM_W-1],
						len_eff);
					rem_nx = st[bpc_pkg::LEN_W-1:0];
					q_nx   = {q_nx[bpc_pkg::CH_W-2:0], st[bpc_pkg::LEN_W]};
					num_nx = num_nx << 1;
				end
			end

			always_ff @(posedge clk) begin
				drem_sn[k][c] <= rem_nx;
				dnum_sn[k][c] <= num_nx;
				dq_sn[k][c]   <= q_nx;
			end
		end

		assign grad_c[8*c +: 8] = dneg[c] ? (cha[c] - dq_sn[bpc_pkg::DIV_STG][c])
			: (cha[c] + dq_sn[bpc_pkg::DIV_STG][c]);
	end

	logic [31:0] pixel_argb_q;

	always_ff @(posedge clk) begin
		case (mode_q)
			bpc_pkg::MODE_HATCH:
				pixel_argb_q <= side_sn[bpc_pkg::LAT-2].hbit ? col1_q : col2_q;
			bpc_pkg::MODE_GRAD:
				pixel_argb_q <= grad_c;
			default:
				pixel_argb_q <= col1_q;
		endcase
	end

	assign pixel_argb = pixel_argb_q;
	assign done       = side_sn[bpc_pkg::LAT-1].valid;

	`BPC_ASSERT_NEXT(a_enter, start && !busy, side_sn[0].valid, "accepted beat did not enter")
	`BPC_ASSERT_SAME(a_latency, done, $past(start && !busy, bpc_pkg::LAT), "done without beat")
	`BPC_ASSERT_NEXT(a_drain, side_sn[bpc_pkg::LAT-2].valid, done, "last stage beat lost")

endmodule
